// File: rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the etdds RTL files.
// No dependencies; each using module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ETDDS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("etdds assertion failed");
`define ETDDS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("etdds assertion failed");
`else
`define ETDDS_ASSERT_NOW(lbl, pre, post)
`define ETDDS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/etdds_pkg.sv
// etdds_pkg: types, reset values and arithmetic constants of the DDS sine block.
// No dependencies; imported by every etdds module.
`default_nettype none

package etdds_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	// result queue, sized above the pipeline depth so it never throttles a full stream
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_W = 13;

	localparam logic [11:0] OFFSET_RST = 12'd1861;
	localparam logic [11:0] AMP_RST    = 12'd1241;
	localparam logic [12:0] FMIN_RST   = 13'd576;
	localparam logic [12:0] FMAX_RST   = 13'd5760;
	localparam logic [12:0] STEPS_RST  = 13'd576;
	localparam logic [31:0] TUNE_RST   = 32'd6442451;
	localparam logic [15:0] COUNT_RST  = 16'h8000;
	localparam logic [11:0] SAMPLE_RST = 12'd1861;
	localparam logic [11:0] DAC_TOP    = 12'd4095;

	// tuning = steps*11184 + floor((steps*608 + 375) / 750)
	localparam logic [13:0] TUNE_WHOLE     = 14'd11184;
	localparam logic [22:0] TUNE_FRAC_BIAS = 23'd375;
	localparam logic [23:0] TUNE_RECIP     = 24'd11453247; // ceil(2^33/750)

	// floor(x/1000) = (x * ceil(2^32/1000)) >> 32 for x < 2^22
	localparam logic [22:0] DIV_RECIP = 23'd4294968;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic {
		KIND_SAMPLE  = 1'b0,
		KIND_ENCODER = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CFG_OFFSET    = 2'd0,
		CFG_AMPLITUDE = 2'd1,
		CFG_FREQ_MIN  = 2'd2,
		CFG_FREQ_MAX  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] encoder_count;
	} item_t;

	typedef struct packed {
		logic [11:0] dac_code;
		logic [12:0] freq_steps;
		logic [31:0] tuning_value;
	} result_t;

	// per-request tag that travels down the sample pipeline
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [12:0] freq_steps;
		logic [31:0] tuning;
	} tag_t;

endpackage

`default_nettype wire

// File: rtl/encoder_tuned_dds_sine_top.sv
// encoder_tuned_dds_sine_top: encoder-tuned DDS sine generator, one result per request.
// Depends on etdds_pkg, etdds_tune, etdds_shape (with etdds_rom) and etdds_fifo.
// Throughput: one request per clock while the queue is not full (item_stall low),
// set by the step-count and phase loops.
// Reset: asynchronous, active low; registers, step count, tuning word, phase,
// last encoder count and last sample return to their power-up values. No clearing pass.
`default_nettype none

module encoder_tuned_dds_sine_top import etdds_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire item_t            item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output result_t               result,
	input  wire logic             cfg_we,
	input  wire cfg_reg_t         cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	// Configuration registers. Writes must land only while the block is idle; the block
	// does not enforce this, and the pipeline reads them directly without snapshotting.
	logic [11:0] offset_q;
	logic [11:0] amplitude_q;
	logic [12:0] steps_floor_q;
	logic [12:0] steps_ceil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= OFFSET_RST;
			amplitude_q   <= AMP_RST;
			steps_floor_q <= FMIN_RST;
			steps_ceil_q  <= FMAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET:    offset_q      <= cfg_data[11:0];
				CFG_AMPLITUDE: amplitude_q   <= cfg_data[11:0];
				CFG_FREQ_MIN:  steps_floor_q <= cfg_data[12:0];
				CFG_FREQ_MAX:  steps_ceil_q  <= cfg_data[12:0];
			endcase
		end
	end

	// Handshakes. A request is taken only when a queue slot is reserved for
	// its result, so the pipeline itself never stalls.
	logic take;
	logic pop;
	logic queue_full;

	assign item_stall = queue_full;
	assign take       = item_valid && !queue_full;
	assign pop        = result_valid && !result_stall;

	// Stages 1-3: encoder delta, step clamp, tuning word, phase accumulate.
	tag_t        tag_s3;
	logic [31:0] phase_s3;

	etdds_tune u_tune (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item),
		.steps_floor(steps_floor_q),
		.steps_ceil (steps_ceil_q),
		.tag_s3     (tag_s3),
		.phase_s3   (phase_s3)
	);

	// Stages 4-8: table index, ROM read, scale, divide, offset/clamp, result register.
	logic    res_valid;
	result_t res;

	etdds_shape #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_shape (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_s3     (tag_s3),
		.phase_s3   (phase_s3),
		.offset     (offset_q),
		.amplitude  (amplitude_q),
		.res_valid_q(res_valid),
		.res_q      (res)
	);

	// Result queue: decouples the output handshake from the input side.
	etdds_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.reserve  (take),
		.push     (res_valid),
		.push_data(res),
		.pop      (pop),
		.full     (queue_full),
		.not_empty(result_valid),
		.head     (result)
	);

endmodule

`default_nettype wire

// File: rtl/etdds_tune.sv
// etdds_tune: encoder delta, clamped step count, tuning word and phase accumulator.
// Depends on etdds_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module etdds_tune import etdds_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire item_t       item,
	input  wire logic [12:0] steps_floor,
	input  wire logic [12:0] steps_ceil,
	output tag_t             tag_s3,
	output logic [31:0]      phase_s3
);

	logic [12:0] steps_q;
	logic [15:0] last_count_q;
	logic [31:0] increment_q;
	logic [31:0] phase_q;

	logic [15:0]        diff;
	logic signed [17:0] sum;
	logic signed [17:0] lo_lim;
	logic signed [17:0] hi_lim;
	logic signed [17:0] lim_a;
	logic signed [17:0] lim_b;
	logic [12:0]        clamped;
	logic               chg;

	always_comb begin
		diff   = item.encoder_count - last_count_q;
		sum    = $signed({5'b0, steps_q}) + $signed({{2{diff[15]}}, diff});
		lo_lim = $signed({5'b0, steps_floor});
		hi_lim = $signed({5'b0, steps_ceil});
		// min first, then max: max wins when the limits cross
		lim_a   = (sum < lo_lim) ? lo_lim : sum;
		lim_b   = (lim_a > hi_lim) ? hi_lim : lim_a;
		clamped = lim_b[12:0];
		chg     = (item.kind == KIND_ENCODER) && (diff != 16'd0);
	end

	// stage 1: step count update
	logic        valid_s1;
	kind_t       kind_s1;
	logic [12:0] steps_s1;
	logic        chg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q      <= STEPS_RST;
			last_count_q <= COUNT_RST;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take && chg) begin
				steps_q      <= clamped;
				last_count_q <= item.encoder_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_s1  <= item.kind;
		steps_s1 <= chg ? clamped : steps_q;
		chg_s1   <= chg;
	end

	// stage 2: tuning word products
	logic [22:0] frac_num;
	logic [46:0] frac_prod;
	logic [26:0] whole_prod;

	always_comb begin
		frac_num = ({10'b0, steps_s1} << 9) + ({10'b0, steps_s1} << 6)
			+ ({10'b0, steps_s1} << 5) + TUNE_FRAC_BIAS;
		frac_prod  = 47'(frac_num) * 47'(TUNE_RECIP);
		whole_prod = 27'(steps_s1) * 27'(TUNE_WHOLE);
	end

	logic        valid_s2;
	kind_t       kind_s2;
	logic [12:0] steps_s2;
	logic        chg_s2;
	logic [26:0] whole_s2;
	logic [13:0] frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2  <= kind_s1;
		steps_s2 <= steps_s1;
		chg_s2   <= chg_s1;
		whole_s2 <= whole_prod;
		frac_s2  <= frac_prod[46:33];
	end

	// stage 3: commit tuning word, advance phase on sample ticks
	logic [31:0] inc_next;
	logic [31:0] phase_next;

	always_comb begin
		inc_next   = (valid_s2 && chg_s2) ? (32'(whole_s2) + 32'(frac_s2)) : increment_q;
		phase_next = phase_q + increment_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			increment_q <= TUNE_RST;
			phase_q     <= 32'd0;
			tag_s3      <= '0;
		end else begin
			increment_q <= inc_next;
			if (valid_s2 && kind_s2 == KIND_SAMPLE) begin
				phase_q <= phase_next;
			end
			tag_s3 <= '{valid: valid_s2, kind: kind_s2, freq_steps: steps_s2, tuning: inc_next};
		end
	end

	always_ff @(posedge clk) begin
		phase_s3 <= phase_next;
	end

	`ETDDS_ASSERT_NEXT(a_phase_hold, !(valid_s2 && kind_s2 == KIND_SAMPLE), $stable(phase_q))
	`ETDDS_ASSERT_NEXT(a_tune_hold, !(valid_s2 && chg_s2), $stable(increment_q))
	`ETDDS_ASSERT_NEXT(a_count_hold, !(take && chg), $stable(last_count_q) && $stable(steps_q))

endmodule

`default_nettype wire

// File: rtl/etdds_rom.sv
// etdds_rom: constant sine table round(1000*sin), registered read.
// Depends on etdds_pkg; contents are built at elaboration from a Q30 series.
`default_nettype none

module etdds_rom import etdds_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
	output logic signed [10:0]                  data_q
);

	logic signed [10:0] rom_c [TABLE_DEPTH];

	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_entry
		localparam logic [31:0] N4  = 32'(4 * gi);
		localparam bit          NEG = (N4 >= 32'(2 * TABLE_DEPTH));
		localparam logic [31:0] NA  = NEG ? (N4 - 32'(2 * TABLE_DEPTH)) : N4;
		localparam logic [31:0] NUM = (NA > 32'(TABLE_DEPTH)) ? (32'(2 * TABLE_DEPTH) - NA) : NA;
		localparam logic [63:0] X   = (HALF_PI_Q30 * 64'(NUM)) / 64'(TABLE_DEPTH);
		localparam logic [63:0] X2  = (X * X) >> 30;
		localparam logic [63:0] T1  = ((X * X2) >> 30) / 64'd6;
		localparam logic [63:0] S1  = (X >= T1) ? (X - T1) : 64'd0;
		localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
		localparam logic [63:0] S2  = S1 + T2;
		localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
		localparam logic [63:0] S3  = (S2 >= T3) ? (S2 - T3) : 64'd0;
		localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
		localparam logic [63:0] S4  = S3 + T4;
		localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
		localparam logic [63:0] S5  = (S4 >= T5) ? (S4 - T5) : 64'd0;
		localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
		localparam logic [63:0] S6  = S5 + T6;
		localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd210;
		localparam logic [63:0] S7  = (S6 >= T7) ? (S6 - T7) : 64'd0;
		localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd272;
		localparam logic [63:0] S8  = S7 + T8;
		localparam logic [63:0] T9  = ((T8 * X2) >> 30) / 64'd342;
		localparam logic [63:0] S9  = (S8 >= T9) ? (S8 - T9) : 64'd0;
		localparam logic [63:0] T10 = ((T9 * X2) >> 30) / 64'd420;
		localparam logic [63:0] S10 = S9 + T10;
		localparam logic [63:0] V   = (S10 * 64'd1000 + (64'd1 << 29)) >> 30;

		assign rom_c[gi] = NEG ? -$signed(11'(V)) : $signed(11'(V));
	end

	always_ff @(posedge clk) begin
		data_q <= rom_c[addr];
	end

endmodule

`default_nettype wire

// File: rtl/etdds_shape.sv
// etdds_shape: table index, sine lookup, amplitude scaling, offset and clamp.
// Depends on etdds_pkg and etdds_rom.
`default_nettype none

module etdds_shape import etdds_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tag_t        tag_s3,
	input  wire logic [31:0] phase_s3,
	input  wire logic [11:0] offset,
	input  wire logic [11:0] amplitude,
	output logic             res_valid_q,
	output result_t          res_q
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int IPW   = 32 + IDX_W;

	// stage 4: entry = floor(phase * depth / 2^32)
	logic [IPW-1:0]   idx_prod;
	logic [IDX_W-1:0] idx_s4;
	tag_t             tag_s4;

	assign idx_prod = IPW'(phase_s3) * IPW'(TABLE_DEPTH);

	always_ff @(posedge clk) begin
		idx_s4 <= idx_prod[IPW-1:32];
	end

	// stage 5: table read
	logic signed [10:0] val_s5;
	tag_t               tag_s5;

	etdds_rom #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.addr  (idx_s4),
		.data_q(val_s5)
	);

	// stage 6: amplitude * |sine|
	logic [9:0]  mag;
	logic [21:0] prod_s6;
	logic        neg_s6;
	tag_t        tag_s6;

	assign mag = val_s5[10] ? 10'(-val_s5) : 10'(val_s5);

	always_ff @(posedge clk) begin
		prod_s6 <= 22'(amplitude) * 22'(mag);
		neg_s6  <= val_s5[10];
	end

	// stage 7: divide by 1000, truncating toward zero
	logic [44:0] quo_prod;
	logic [11:0] quo_s7;
	logic        neg_s7;
	tag_t        tag_s7;

	assign quo_prod = 45'(prod_s6) * 45'(DIV_RECIP);

	always_ff @(posedge clk) begin
		quo_s7 <= quo_prod[43:32];
		neg_s7 <= neg_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else begin
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
		end
	end

	// result: offset, clamp, hold last sample for encoder requests
	logic signed [13:0] sv;
	logic [11:0]        sample_code;
	logic               is_sample;
	logic [11:0]        last_sample_q;

	always_comb begin
		sv = neg_s7 ? ($signed({2'b0, offset}) - $signed({2'b0, quo_s7}))
			: ($signed({2'b0, offset}) + $signed({2'b0, quo_s7}));
		if (sv[13]) begin
			sample_code = 12'd0;
		end else if (sv > $signed({2'b0, DAC_TOP})) begin
			sample_code = DAC_TOP;
		end else begin
			sample_code = sv[11:0];
		end
		is_sample = tag_s7.valid && tag_s7.kind == KIND_SAMPLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= SAMPLE_RST;
			res_valid_q   <= 1'b0;
		end else begin
			res_valid_q <= tag_s7.valid;
			if (is_sample) begin
				last_sample_q <= sample_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q.dac_code     <= is_sample ? sample_code : last_sample_q;
		res_q.freq_steps   <= tag_s7.freq_steps;
		res_q.tuning_value <= tag_s7.tuning;
	end

endmodule

`default_nettype wire

// File: rtl/etdds_fifo.sv
// etdds_fifo: result queue with credit count that throttles the input side.
// Depends on etdds_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module etdds_fifo import etdds_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    reserve,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    pop,
	output logic         full,
	output logic         not_empty,
	output result_t      head
);

	result_t          mem [FIFO_DEPTH];
	result_t          head_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] rd_addr;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] credit_q;

	assign full      = (credit_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = head_q;

	// registered read of the entry that is at the head after this edge;
	// a push into that same entry is forwarded
	assign rd_addr = pop ? (rd_ptr_q + 1'b1) : rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (push && wr_ptr_q == rd_addr) begin
			head_q <= push_data;
		end else begin
			head_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
			case ({reserve, pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	`ETDDS_ASSERT_NOW(a_fill_le_credit, 1'b1, fill_q <= credit_q)
	`ETDDS_ASSERT_NOW(a_push_room, push, fill_q < CNT_W'(FIFO_DEPTH))
	`ETDDS_ASSERT_NOW(a_pop_nonempty, pop, fill_q != '0)

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking bench for the encoder-tuned DDS sine block.
// Uses etdds_pkg for the port types; a class mirrors the phase, tuning and DAC math.
`default_nettype none

module tb_top;
	import etdds_pkg::*;

	// pi/2 in Q30, the argument scale of the sine series
	localparam bit [63:0] RIGHT_ANGLE_Q30 = 64'd1686629713;
	localparam int        ROM_ENTRIES     = 256;
	localparam int        SINE_PEAK       = 1000;
	localparam int        CODE_MAX        = 4095;
	localparam bit [63:0] STEPS_PER_CYCLE = 64'd384000;
	localparam int        DRAIN_CYCLES    = 12;
	localparam int        REPORT_CAP      = 40;

	// Mirror of the generator: keeps its own registers, phase, step count and
	// last encoder count, and queues the output each request should produce.
	class sine_dds_mirror;
		int          sine_rom[ROM_ENTRIES];
		logic [11:0] offset, amplitude;
		logic [12:0] steps_lo, steps_hi;
		logic [31:0] phase_word, tuning;
		logic [12:0] steps;
		logic [15:0] last_count;
		logic [11:0] last_code;
		result_t     outputs_due[$];
		int          bad_fields;
		int          outputs_seen;

		// round(1000*sin((pi/2)*num/den)) by a fixed-point Taylor series
		function int quarter_sine(int unsigned num, int unsigned den);
			bit [63:0] x, x2, term, sum;
			x = (RIGHT_ANGLE_Q30 * num) / den;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int unsigned k = 1; k <= 10; k++) begin
				term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
				if (k[0])
					sum = (sum >= term) ? sum - term : 64'd0;
				else
					sum += term;
			end
			return int'((sum * 64'd1000 + (64'd1 << 29)) >> 30);
		endfunction

		function logic [31:0] tuning_for(logic [12:0] s);
			bit [63:0] t;
			t = ((64'(s) << 32) + STEPS_PER_CYCLE / 2) / STEPS_PER_CYCLE;
			return t[31:0];
		endfunction

		function void restart();
			int unsigned n;
			bit          neg;
			for (int i = 0; i < ROM_ENTRIES; i++) begin
				n = 4 * i;
				neg = (n >= 2 * ROM_ENTRIES);
				if (neg)
					n -= 2 * ROM_ENTRIES;
				if (n > ROM_ENTRIES)
					n = 2 * ROM_ENTRIES - n;
				sine_rom[i] = neg ? -quarter_sine(n, ROM_ENTRIES) : quarter_sine(n, ROM_ENTRIES);
			end
			offset = 12'd1861;
			amplitude = 12'd1241;
			steps_lo = 13'd576;
			steps_hi = 13'd5760;
			phase_word = '0;
			steps = 13'd576;
			tuning = tuning_for(steps);
			last_count = 16'h8000;
			last_code = 12'd1861;
			bad_fields = 0;
			outputs_seen = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [12:0] v);
			case (r)
				CFG_OFFSET:    offset = v[11:0];
				CFG_AMPLITUDE: amplitude = v[11:0];
				CFG_FREQ_MIN:  steps_lo = v;
				CFG_FREQ_MAX:  steps_hi = v;
				default: ;
			endcase
		endfunction

		function void take_request(item_t it);
			logic [15:0] diff;
			int          delta, s, v;
			result_t     r;
			if (it.kind == KIND_SAMPLE) begin
				phase_word += tuning;
				// C-style division: truncates toward zero for negative lobes
				v = int'(offset) + (int'(amplitude) * sine_rom[phase_word[31:24]]) / SINE_PEAK;
				if (v < 0)
					v = 0;
				if (v > CODE_MAX)
					v = CODE_MAX;
				last_code = 12'(v);
			end else begin
				diff = it.encoder_count - last_count;
				delta = int'($signed(diff));
				if (delta != 0) begin
					s = int'(steps) + delta;
					last_count = it.encoder_count;
					// low limit first, so the high one wins when the two cross
					if (s < int'(steps_lo))
						s = int'(steps_lo);
					if (s > int'(steps_hi))
						s = int'(steps_hi);
					steps = 13'(s);
					tuning = tuning_for(steps);
				end
			end
			r.dac_code = last_code;
			r.freq_steps = steps;
			r.tuning_value = tuning;
			outputs_due.push_back(r);
		endfunction

		function void flag(string field, longint unsigned e, longint unsigned a);
			bad_fields++;
			if (bad_fields <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
		endfunction

		function void match_output(result_t got);
			result_t e;
			outputs_seen++;
			if (outputs_due.size() == 0) begin
				bad_fields++;
				$display("%0t: result with nothing outstanding, expected none, actual %h",
					$time, got);
				return;
			end
			e = outputs_due.pop_front();
			if (got.dac_code !== e.dac_code)
				flag("dac_code", e.dac_code, got.dac_code);
			if (got.freq_steps !== e.freq_steps)
				flag("freq_steps", e.freq_steps, got.freq_steps);
			if (got.tuning_value !== e.tuning_value)
				flag("tuning_value", e.tuning_value, got.tuning_value);
		endfunction

		function int pending();
			return outputs_due.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_we = 1'b0;
	cfg_reg_t         cfg_index = CFG_OFFSET;
	logic [CFG_W-1:0] cfg_data = '0;

	sine_dds_mirror sb;

	int unsigned idle_pct = 0;    // chance the sender skips a cycle
	int unsigned stall_pct = 0;   // chance the receiver stalls a cycle
	int          hold_asked = 0;  // long receiver hold-off, handed to the sink process
	int          hold_left = 0;
	logic [15:0] last_sent = 16'h8000;  // last encoder reading the block has taken
	int          ticks_sent = 0;
	int          readings_sent = 0;
	int          settings_loaded = 0;
	int          input_blocked = 0;

	encoder_tuned_dds_sine_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result sink: checks each accepted result, then picks the next stall value.
	// A requested hold-off keeps stall high while its count runs down, so the
	// result queue fills and the block pushes back on its input.
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			sb.match_output(result);
		if (hold_asked != 0) begin
			hold_left = hold_asked;
			hold_asked = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	// Offer one request and hold it until the block takes it. Valid is decided
	// before the request goes out and never looks at stall.
	task automatic send_request(item_t it);
		while ($urandom_range(99, 0) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do begin
			@(posedge clk);
			if (item_stall)
				input_blocked++;
		end while (item_stall);
		sb.take_request(it);
		if (it.kind == KIND_ENCODER) begin
			last_sent = it.encoder_count;
			readings_sent++;
		end else begin
			ticks_sent++;
		end
	endtask

	function automatic item_t make_request(kind_t k, logic [15:0] c);
		item_t it;
		it.kind = k;
		it.encoder_count = c;
		return it;
	endfunction

	// Mostly small encoder moves around the last reading so the frequency walks
	// between the limits; some zero moves, jumps, half-range wraps and wild readings.
	function automatic item_t random_request();
		item_t       it;
		int unsigned pick, mag;
		logic [15:0] move;
		it.encoder_count = 16'($urandom);
		if ($urandom_range(99, 0) < 55) begin
			it.kind = KIND_SAMPLE;
			return it;
		end
		it.kind = KIND_ENCODER;
		pick = $urandom_range(99, 0);
		if (pick < 60)
			mag = $urandom_range(40, 1);
		else if (pick < 70)
			mag = 0;
		else if (pick < 80)
			mag = $urandom_range(3000, 100);
		else if (pick < 85)
			mag = 32768;
		else
			return it;
		move = $urandom_range(1, 0) ? 16'(mag) : 16'(-int'(mag));
		it.encoder_count = last_sent + move;
		return it;
	endfunction

	task automatic put_reg(cfg_reg_t r, logic [12:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		sb.set_reg(r, v);
		@(posedge clk);
	endtask

	// Registers only change with nothing in flight.
	task automatic load_registers(logic [11:0] off, logic [11:0] amp,
			logic [12:0] lo, logic [12:0] hi);
		put_reg(CFG_OFFSET, {1'b0, off});
		put_reg(CFG_AMPLITUDE, {1'b0, amp});
		put_reg(CFG_FREQ_MIN, lo);
		put_reg(CFG_FREQ_MAX, hi);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Drop valid, wait for every outstanding result, then let the pipe empty.
	task automatic settle();
		int guard;
		guard = 0;
		item_valid <= 1'b0;
		while (sb.pending() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [11:0] off, logic [11:0] amp, logic [12:0] lo,
			logic [12:0] hi, int unsigned idle, int unsigned stall, int hold, int count);
		settle();
		load_registers(off, amp, lo, hi);
		idle_pct = idle;
		stall_pct = stall;
		hold_asked = hold;
		repeat (count) send_request(random_request());
	endtask

	// Directed opening at reset settings: ignored count on ticks, zero moves,
	// +/-1 steps against the low limit, full-range jumps into both limits and
	// the half-range move that reads as -32768.
	task automatic opening_requests();
		send_request(make_request(KIND_SAMPLE, 16'h0000));
		send_request(make_request(KIND_SAMPLE, 16'hFFFF));
		send_request(make_request(KIND_SAMPLE, 16'h5A5A));
		send_request(make_request(KIND_ENCODER, 16'h8000));
		send_request(make_request(KIND_ENCODER, 16'h8001));
		send_request(make_request(KIND_ENCODER, 16'h8000));
		send_request(make_request(KIND_ENCODER, 16'h7FFF));
		send_request(make_request(KIND_ENCODER, 16'h83E7));
		send_request(make_request(KIND_SAMPLE, 16'h0000));
		send_request(make_request(KIND_ENCODER, 16'h0000));
		send_request(make_request(KIND_ENCODER, 16'h8000));
		send_request(make_request(KIND_ENCODER, 16'hFFFF));
		send_request(make_request(KIND_ENCODER, 16'h7FFF));
		send_request(make_request(KIND_ENCODER, 16'h7FFF));
		send_request(make_request(KIND_SAMPLE, 16'hFFFF));
		send_request(make_request(KIND_SAMPLE, 16'h1234));
		send_request(make_request(KIND_ENCODER, 16'hFFFF));
		send_request(make_request(KIND_ENCODER, 16'h0000));
		repeat (3) send_request(make_request(KIND_SAMPLE, 16'($urandom)));
	endtask

	initial begin
		sb = new;
		sb.restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		opening_requests();

		// offset, amplitude, low, high limits; sender idle %, receiver stall %;
		// hold-off cycles; requests
		run_phase(12'd1861, 12'd1241, 13'd576, 13'd5760, 0, 0, 0, 200);
		run_phase(12'd4095, 12'd4095, 13'd0, 13'd8191, 52, 0, 0, 200);
		run_phase(12'd0, 12'd4095, 13'd0, 13'd8191, 0, 52, 0, 200);
		run_phase(12'd0, 12'd0, 13'd8191, 13'd8191, 15, 15, 0, 200);
		// crossed limits, plus a long receiver hold-off under a full-rate sender
		run_phase(12'd2048, 12'd2047, 13'd5000, 13'd100, 0, 0, 80, 200);
		run_phase(12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom), 52, 0, 0, 200);
		run_phase(12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom), 0, 52, 0, 200);
		run_phase(12'd4095, 12'd0, 13'd0, 13'd0, 15, 15, 0, 200);
		run_phase(12'd1024, 12'd3000, 13'd1, 13'd8190, 0, 0, 0, 200);

		settle();
		if (sb.pending() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending());
		$display("Covered %0d sample ticks and %0d encoder readings over %0d settings;",
			ticks_sent, readings_sent, settings_loaded);
		$display("%0d results checked, input held off on %0d cycles, %0d field errors.",
			sb.outputs_seen, input_blocked, sb.bad_fields);
		if (sb.bad_fields == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Run bound: far above the slowest correct run of the whole stimulus.
	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/etdds_pkg.sv
rtl/etdds_tune.sv
rtl/etdds_rom.sv
rtl/etdds_shape.sv
rtl/etdds_fifo.sv
rtl/encoder_tuned_dds_sine_top.sv
dv/tb_top.sv
